@@ hdl/fsr_pkg.sv @@
// Shared types and constants for the binary64 square root core.
`timescale 1ns / 1ps
`default_nettype none
package fsr_pkg;

  localparam int SIG_W  = 54;
  localparam int REM_W  = 57;
  localparam int EXP_W  = 11;
  localparam int DIGITS = 54;

  localparam logic [1:0] RM_NEAREST = 2'd0;
  localparam logic [1:0] RM_DOWN    = 2'd1;
  localparam logic [1:0] RM_UP      = 2'd2;

  localparam logic [10:0] EXP_ALL   = 11'h7ff;
  localparam logic [10:0] EXP_BIAS2 = 11'd1022;
  localparam logic [63:0] INF_BITS  = 64'h7ff0_0000_0000_0000;

  typedef struct packed {
    logic               byp;
    logic               dom;
    logic [63:0]        byp_bits;
    logic [SIG_W-1:0]   sig;
    logic [EXP_W-1:0]   half;
  } fsr_item_t;

  typedef struct packed {
    logic               byp;
    logic               dom;
    logic [63:0]        byp_bits;
    logic [SIG_W-1:0]   sig;
    logic [EXP_W-1:0]   half;
    logic [SIG_W-1:0]   q;
    logic [REM_W-1:0]   rem;
  } fsr_stage_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fsr_qstat_t;

endpackage
`default_nettype wire

@@ hdl/fsr_front.sv @@
// Front end: accepts operands, classifies them and normalizes the significand.
`timescale 1ns / 1ps
`default_nettype none
module fsr_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire [63:0]           in_operand_bits,
  input  fsr_pkg::fsr_qstat_t  q_stat,
  output logic                 push,
  output fsr_pkg::fsr_item_t   push_item
);
  import fsr_pkg::*;

  logic        a_valid_r, a_valid_nxt;
  logic [63:0] a_x_r;
  logic        b_valid_r, b_valid_nxt;
  logic [63:0] b_x_r;
  logic [5:0]  b_lz_r;
  logic [5:0]  lz;
  logic        a_ready, b_ready;

  logic [10:0]        ex;
  logic [51:0]        frac;
  logic [5:0]         shamt;
  logic signed [11:0] eb, e;
  logic signed [11:0] e_even;
  logic [52:0]        sig53;
  logic               odd;

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 52; i++) begin
      if (a_x_r[i]) lz = 6'(51 - i);
    end
  end

  assign b_ready  = !b_valid_r || !q_stat.full;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_stall = !a_ready;
  assign push     = b_valid_r && !q_stat.full;

  assign a_valid_nxt = a_ready ? in_valid : a_valid_r;
  assign b_valid_nxt = b_ready ? a_valid_r : b_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) a_x_r <= in_operand_bits;
    if (b_ready && a_valid_r) begin
      b_x_r  <= a_x_r;
      b_lz_r <= lz;
    end
  end

  always_comb begin
    ex   = b_x_r[62:52];
    frac = b_x_r[51:0];
    push_item = '0;
    if (b_x_r[62:0] == 63'd0) begin
      push_item.byp      = 1'b1;
      push_item.byp_bits = b_x_r;
    end else if (b_x_r[63] || (ex == EXP_ALL && frac != 52'd0)) begin
      push_item.byp = 1'b1;
      push_item.dom = 1'b1;
    end else if (ex == EXP_ALL) begin
      push_item.byp      = 1'b1;
      push_item.byp_bits = INF_BITS;
    end
    if (ex == 11'd0) begin
      shamt = b_lz_r + 6'd1;
      eb    = -12'sd1022;
      sig53 = {1'b0, frac} << shamt;
    end else begin
      shamt = 6'd0;
      eb    = $signed({1'b0, ex}) - 12'sd1023;
      sig53 = {1'b1, frac};
    end
    e      = eb - $signed({6'd0, shamt});
    odd    = e[0];
    e_even = e - $signed({11'd0, odd});
    push_item.sig  = odd ? {sig53, 1'b0} : {1'b0, sig53};
    push_item.half = e_even[11:1];
  end

endmodule
`default_nettype wire

@@ hdl/fsr_queue.sv @@
// Small register queue between the front end and the root pipeline.
`timescale 1ns / 1ps
`default_nettype none
module fsr_queue #(
  parameter int DEPTH = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  fsr_pkg::fsr_item_t   din,
  input  wire                  pop,
  output fsr_pkg::fsr_item_t   dout,
  output fsr_pkg::fsr_qstat_t  stat
);
  import fsr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fsr_item_t       mem_r [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign dout       = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (pop)  rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

endmodule
`default_nettype wire

@@ hdl/fsr_back.sv @@
// Root pipeline: one restoring digit per stage, then rounding and packing.
`timescale 1ns / 1ps
`default_nettype none
module fsr_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire [1:0]            rounding_mode,
  input  fsr_pkg::fsr_qstat_t  q_stat,
  input  fsr_pkg::fsr_item_t   q_item,
  output logic                 pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [63:0]          out_root_bits,
  output logic                 out_domain_error,
  output logic                 out_inexact
);
  import fsr_pkg::*;

  fsr_stage_t  pipe_r   [1:DIGITS];
  fsr_stage_t  stg_in   [1:DIGITS];
  fsr_stage_t  stg_nxt  [1:DIGITS];
  logic [DIGITS:1] v_r;
  logic        en;
  logic        o_valid_r;
  logic [63:0] o_bits_r, o_bits_nxt;
  logic        o_dom_r, o_dom_nxt, o_inx_r, o_inx_nxt;
  logic [54:0] qr;
  logic [10:0] expf;

  assign en  = !(o_valid_r && out_stall);
  assign pop = en && !q_stat.empty;

  always_comb begin
    stg_in[1]          = '0;
    stg_in[1].byp      = q_item.byp;
    stg_in[1].dom      = q_item.dom;
    stg_in[1].byp_bits = q_item.byp_bits;
    stg_in[1].sig      = q_item.sig;
    stg_in[1].half     = q_item.half;
    for (int k = 2; k <= DIGITS; k++) stg_in[k] = pipe_r[k-1];
  end

  for (genvar k = 1; k <= DIGITS; k++) begin : g_dig
    localparam int I = DIGITS - k;
    logic [1:0]       pair;
    logic [REM_W-1:0] rsh, trial;
    logic [REM_W:0]   diff;
    if (I >= 27) begin : g_sig
      assign pair = {stg_in[k].sig[2*I-53], stg_in[k].sig[2*I-54]};
    end else begin : g_zero
      assign pair = 2'b00;
    end
    always_comb begin
      rsh   = {stg_in[k].rem[REM_W-3:0], pair};
      trial = {1'b0, stg_in[k].q, 2'b01};
      diff  = {1'b0, rsh} - {1'b0, trial};
      stg_nxt[k] = stg_in[k];
      if (!diff[REM_W]) begin
        stg_nxt[k].rem = diff[REM_W-1:0];
        stg_nxt[k].q   = {stg_in[k].q[SIG_W-2:0], 1'b1};
      end else begin
        stg_nxt[k].rem = rsh;
        stg_nxt[k].q   = {stg_in[k].q[SIG_W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) pipe_r[k] <= stg_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      o_valid_r <= 1'b0;
    end else if (en) begin
      v_r       <= {v_r[DIGITS-1:1], pop};
      o_valid_r <= v_r[DIGITS];
    end
  end

  always_comb begin
    o_inx_nxt = 1'b0;
    qr        = {1'b0, pipe_r[DIGITS].q};
    expf      = pipe_r[DIGITS].half + EXP_BIAS2;
    if (pipe_r[DIGITS].rem != '0) begin
      o_inx_nxt = 1'b1;
      case (rounding_mode)
        RM_UP:   qr = qr + 55'd2;
        RM_DOWN: qr = qr;
        default: qr = qr + {54'd0, qr[0]};
      endcase
    end
    o_bits_nxt = {1'b0, expf, 52'd0} + {10'd0, qr[54:1]};
    o_dom_nxt  = 1'b0;
    if (pipe_r[DIGITS].byp) begin
      o_bits_nxt = pipe_r[DIGITS].byp_bits;
      o_dom_nxt  = pipe_r[DIGITS].dom;
      o_inx_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_bits_r <= o_bits_nxt;
      o_dom_r  <= o_dom_nxt;
      o_inx_r  <= o_inx_nxt;
    end
  end

  assign out_valid        = o_valid_r;
  assign out_root_bits    = o_bits_r;
  assign out_domain_error = o_dom_r;
  assign out_inexact      = o_inx_r;

endmodule
`default_nettype wire

@@ hdl/fp64_square_root_core.sv @@
// Top level of the binary64 square root core.
`timescale 1ns / 1ps
`default_nettype none
// Takes one binary64 operand per cycle while in_stall is low and returns its
// correctly rounded root in the order taken. The path runs through two
// front-end stages, the queue, 54 digit stages and the output register.
// Negative nonzero operands and NaNs give +0 with domain_error; zeros pass
// through, +inf gives +inf.
// rounding_mode: 0 nearest even, 1 down, 2 up; write it only while idle.
module fp64_square_root_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire [1:0]   cfg_wdata,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire [63:0]  in_operand_bits,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [63:0] out_root_bits,
  output logic        out_domain_error,
  output logic        out_inexact
);
  import fsr_pkg::*;

  logic [1:0] mode_r;
  fsr_qstat_t q_stat;
  fsr_item_t  push_item, q_item;
  logic       push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= RM_NEAREST;
    else if (cfg_we) mode_r <= cfg_wdata;
  end

  fsr_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_operand_bits,
    .q_stat, .push, .push_item
  );

  fsr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push, .din(push_item), .pop, .dout(q_item), .stat(q_stat)
  );

  fsr_back u_back (
    .clk, .rst_n, .rounding_mode(mode_r), .q_stat, .q_item, .pop,
    .out_valid, .out_stall, .out_root_bits, .out_domain_error, .out_inexact
  );

endmodule
`default_nettype wire

@@ hdl/fsr_checker.sv @@
// Port-level checks for the square root core and their bind.
`timescale 1ns / 1ps
`default_nettype none
module fsr_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_stall,
  input wire [63:0] out_root_bits,
  input wire        out_domain_error,
  input wire        out_inexact
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_root_bits))
    else $error("stalled transfer changed");

  a_dom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_domain_error |-> out_root_bits == 64'd0 && !out_inexact)
    else $error("domain error without +0 result");

  a_inx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inexact |-> !out_root_bits[63] && out_root_bits[62:52] != 11'h7ff)
    else $error("inexact result not finite positive");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");

endmodule

bind fp64_square_root_core fsr_checker u_fsr_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_root_bits, .out_domain_error, .out_inexact
);
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the binary64 square root core.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import fsr_pkg::*;

  typedef struct {
    logic [63:0] root_bits;
    logic        domain_error;
    logic        inexact;
  } root_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_operand_bits;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_root_bits;
  logic        out_domain_error;
  logic        out_inexact;

  logic [1:0]   round_mode;
  root_result_t expected_roots[$];
  int           mismatches;
  int           results_seen;
  int           operands_sent;
  bit           sink_busy;

  fp64_square_root_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operand_bits  (in_operand_bits),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_root_bits    (out_root_bits),
    .out_domain_error (out_domain_error),
    .out_inexact      (out_inexact)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("fp64_square_root_core: mismatch");
    $finish;
  end

  function automatic root_result_t predict_root(logic [63:0] x);
    root_result_t r;
    logic [10:0]  ex;
    logic [51:0]  frac;
    logic [54:0]  sig;
    logic [107:0] radicand;
    logic [55:0]  q;
    logic [111:0] rem;
    logic [111:0] trial;
    int           e;
    int           half;
    r.root_bits = 64'd0;
    r.domain_error = 1'b0;
    r.inexact = 1'b0;
    ex = x[62:52];
    frac = x[51:0];
    if (x[62:0] == 63'd0) begin
      r.root_bits = x;
      return r;
    end
    if (x[63] || (ex == EXP_ALL && frac != 0)) begin
      r.domain_error = 1'b1;
      return r;
    end
    if (ex == EXP_ALL) begin
      r.root_bits = INF_BITS;
      return r;
    end
    if (ex == 0) begin
      sig = {3'b000, frac};
      e = -1022;
      while (!sig[52]) begin
        sig = sig << 1;
        e = e - 1;
      end
    end else begin
      sig = {3'b001, frac};
      e = int'(ex) - 1023;
    end
    if (e % 2 != 0) begin
      sig = sig << 1;
      e = e - 1;
    end
    half = e / 2;
    radicand = {sig[53:0], 54'd0};
    q = 0;
    rem = 0;
    for (int i = 53; i >= 0; i--) begin
      rem = (rem << 2) | radicand[2*i +: 2];
      trial = ({56'd0, q} << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        q = (q << 1) | 1;
      end else begin
        q = q << 1;
      end
    end
    if (rem != 0) begin
      r.inexact = 1'b1;
      if (round_mode == RM_UP) q = q + 2;
      else if (round_mode != RM_DOWN) q = q + q[0];
    end
    r.root_bits = (64'(half + 1022) << 52) + 64'(q >> 1);
    return r;
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    root_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_roots.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected result %h", out_root_bits);
      end else begin
        exp_r = expected_roots.pop_front();
        if (exp_r.root_bits !== out_root_bits || exp_r.domain_error !== out_domain_error ||
            exp_r.inexact !== out_inexact) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("root mismatch: exp %h dom %b inx %b, got %h dom %b inx %b",
                     exp_r.root_bits, exp_r.domain_error, exp_r.inexact,
                     out_root_bits, out_domain_error, out_inexact);
        end
      end
    end
    out_stall <= sink_busy ? ($urandom_range(0, 99) < 30) : 1'b0;
  end

  task automatic send_operand(logic [63:0] x, bit gaps);
    while (gaps && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operand_bits <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_roots.push_back(predict_root(x));
    operands_sent++;
  endtask

  task automatic drain_roots();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (expected_roots.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  task automatic set_rounding(logic [1:0] mode);
    drain_roots();
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    round_mode = mode;
  endtask

  function automatic logic [63:0] random_operand();
    logic [63:0] x;
    x = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: x[62:52] = 11'd0;
      1: x[62:52] = EXP_ALL;
      2: x = 64'd0 | $urandom_range(1, 255);
      3: x[51:0] = 52'd0;
      default: x[63] = ($urandom_range(0, 9) == 0);
    endcase
    return x;
  endfunction

  task automatic test_special_values();
    send_operand(64'h0000_0000_0000_0000, 1'b0);
    send_operand(64'h8000_0000_0000_0000, 1'b0);
    send_operand(64'h7ff0_0000_0000_0000, 1'b0);
    send_operand(64'hfff0_0000_0000_0000, 1'b0);
    send_operand(64'h7ff8_0000_0000_0000, 1'b0);
    send_operand(64'hffff_ffff_ffff_ffff, 1'b0);
    send_operand(64'h7ff0_0000_0000_0001, 1'b0);
    send_operand(64'hbff0_0000_0000_0000, 1'b0);
  endtask

  task automatic test_extremes();
    send_operand(64'h0000_0000_0000_0001, 1'b0);
    send_operand(64'h000f_ffff_ffff_ffff, 1'b0);
    send_operand(64'h0010_0000_0000_0000, 1'b0);
    send_operand(64'h7fef_ffff_ffff_ffff, 1'b0);
    send_operand(64'h3ff0_0000_0000_0000, 1'b0);
    send_operand(64'h4000_0000_0000_0000, 1'b0);
    send_operand(64'h4010_0000_0000_0000, 1'b0);
    send_operand(64'h3fff_ffff_ffff_ffff, 1'b0);
    send_operand(64'h3fef_ffff_ffff_ffff, 1'b0);
    send_operand(64'h5555_5555_5555_5555, 1'b0);
    send_operand(64'h2aaa_aaaa_aaaa_aaaa, 1'b0);
  endtask

  task automatic test_random(int count, bit gaps);
    for (int i = 0; i < count; i++) send_operand(random_operand(), gaps);
  endtask

  task automatic test_rounding_modes();
    logic [1:0] modes[4] = '{RM_DOWN, RM_UP, 2'd3, RM_NEAREST};
    foreach (modes[m]) begin
      set_rounding(modes[m]);
      test_extremes();
      test_random(60, 1'b1);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 2'd0;
    in_valid = 1'b0;
    in_operand_bits = 64'd0;
    out_stall = 1'b0;
    round_mode = RM_NEAREST;
    mismatches = 0;
    results_seen = 0;
    operands_sent = 0;
    sink_busy = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_values();
    test_extremes();
    drain_roots();
    sink_busy = 1'b1;
    test_random(150, 1'b1);
    sink_busy = 1'b0;
    test_random(60, 1'b0);
    sink_busy = 1'b1;
    test_rounding_modes();
    drain_roots();
    $display("covered %0d operands, %0d results, all four rounding settings",
             operands_sent, results_seen);
    $display("incl. zeros, infinities, NaNs, negatives, subnormals, stalls, gaps");
    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("fp64_square_root_core: match");
    end else begin
      $display("fp64_square_root_core: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
hdl/fsr_pkg.sv
hdl/fsr_front.sv
hdl/fsr_queue.sv
hdl/fsr_back.sv
hdl/fp64_square_root_core.sv
hdl/fsr_checker.sv
verif/tb_top.sv
